// ===== hw/rtl/dtsc_pkg.sv =====
// package: type codes, payload structs and widths for the double conversion core
`default_nettype none
package dtsc_pkg;
    typedef enum logic [3:0] {
        K_BOOL = 4'd0, K_S8 = 4'd1, K_U8 = 4'd2, K_S16 = 4'd3, K_U16 = 4'd4,
        K_S32 = 4'd5, K_U32 = 4'd6, K_S64 = 4'd7, K_U64 = 4'd8, K_F32 = 4'd9,
        K_F64 = 4'd10
    } t_kind;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [3:0]  kind;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_bits;
        logic [3:0]  size_bytes;
        logic        invalid;
    } t_out_item;

    // decoded source fields handed from the input stage to the converters
    typedef struct packed {
        logic        neg;
        logic [10:0] ex;
        logic [51:0] fr;
        logic        is_nan;
        logic        is_inf;
    } t_fp64_fields;
endpackage
`default_nettype wire

// ===== hw/rtl/dtsc_if.sv =====
// valid/ready channel interfaces for input and result transactions
`default_nettype none
interface dtsc_in_if;
    import dtsc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtsc_out_if;
    import dtsc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dtsc_int_conv.sv =====
// fp64 to integer conversion with truncation and saturation
`default_nettype none
module dtsc_int_conv (
    input  var dtsc_pkg::t_fp64_fields i_f,
    input  var logic [3:0]             i_kind,
    output logic [63:0]                o_bits,
    output logic                       o_invalid
);
    import dtsc_pkg::*;

    logic        big;
    logic [63:0] mag;
    logic [63:0] m64;
    logic [10:0] e;
    logic [6:0]  w;
    logic        sgn;
    logic [63:0] mask;
    logic [63:0] lim;
    logic [63:0] negmag;

    always_comb begin
        m64 = {11'd0, 1'b1, i_f.fr};
        e   = i_f.ex - 11'd1023;
        big = i_f.is_inf;
        mag = '0;
        if (!i_f.is_nan && !i_f.is_inf && i_f.ex >= 11'd1023) begin
            if (e >= 11'd64) begin
                big = 1'b1;
            end else if (e >= 11'd52) begin
                mag = m64 << (e[5:0] - 6'd52);
            end else begin
                mag = m64 >> (6'd52 - e[5:0]);
            end
        end
        unique case (i_kind)
            K_S8:    begin w = 7'd8;  sgn = 1'b1; end
            K_U8:    begin w = 7'd8;  sgn = 1'b0; end
            K_S16:   begin w = 7'd16; sgn = 1'b1; end
            K_U16:   begin w = 7'd16; sgn = 1'b0; end
            K_S32:   begin w = 7'd32; sgn = 1'b1; end
            K_U32:   begin w = 7'd32; sgn = 1'b0; end
            K_S64:   begin w = 7'd64; sgn = 1'b1; end
            default: begin w = 7'd64; sgn = 1'b0; end
        endcase
        mask   = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
        lim    = 64'd1 << (w[5:0] - 6'd1);
        negmag = (64'd0 - mag) & mask;
        o_invalid = 1'b0;
        if (i_f.is_nan) begin
            o_bits    = '0;
            o_invalid = 1'b1;
        end else if (sgn) begin
            if (i_f.neg) begin
                if (big || mag > lim) begin
                    o_bits = lim & mask;
                    o_invalid = 1'b1;
                end else begin
                    o_bits = negmag;
                end
            end else if (big || mag > lim - 64'd1) begin
                o_bits = lim - 64'd1;
                o_invalid = 1'b1;
            end else begin
                o_bits = mag;
            end
        end else if (i_f.neg) begin
            o_bits    = '0;
            o_invalid = big || (mag != 64'd0);
        end else if (big || mag > mask) begin
            o_bits    = mask;
            o_invalid = 1'b1;
        end else begin
            o_bits = mag;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dtsc_f32_conv.sv =====
// fp64 to fp32 rounding to nearest even
`default_nettype none
module dtsc_f32_conv (
    input  var dtsc_pkg::t_fp64_fields i_f,
    output logic [31:0]                o_bits
);
    import dtsc_pkg::*;

    logic [63:0] m;
    logic [12:0] e32;
    logic [6:0]  sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] qr;
    logic [12:0] e_adj;
    logic        s;
    logic        norm;

    always_comb begin
        s    = i_f.neg;
        m    = {11'd0, 1'b1, i_f.fr};
        e32  = {2'b00, i_f.ex} - 13'd896;
        norm = !e32[12] && (e32 != 13'd0);
        // shift 29 for normal results, wider for single subnormals
        sh   = norm ? 7'd29 : (7'd30 - e32[6:0]);
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 7'd1);
        qr   = q + {63'd0, (rem > half) || ((rem == half) && q[0])};
        e_adj = e32;
        if (qr == 64'd1 << 24) begin
            e_adj = e32 + 13'd1;
        end
        if (i_f.is_nan) begin
            o_bits = {s, 9'h1FF, 22'd0} | {10'd0, i_f.fr[50:29]};
        end else if (i_f.is_inf) begin
            o_bits = {s, 8'hFF, 23'd0};
        end else if (i_f.ex == 11'd0) begin
            o_bits = {s, 31'd0};
        end else if (norm) begin
            if (e_adj >= 13'd255) begin
                o_bits = {s, 8'hFF, 23'd0};
            end else if (qr == 64'd1 << 24) begin
                o_bits = {s, e_adj[7:0], 23'd0};
            end else begin
                o_bits = {s, e_adj[7:0], qr[22:0]};
            end
        end else if (!(e32[12] && e32 <= 13'h1FD8) && sh <= 7'd63) begin
            o_bits = {s, qr[30:0]};
        end else begin
            o_bits = {s, 31'd0};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/double_to_typed_scalar_convert_core.sv =====
// top level: registered fp64 to typed scalar converter
// One transaction in, one transaction out, one per clock. Each accepted value
// lands in an input register; the integer and single converters plus a type
// select sit between that register and the result register, so the result is
// valid once it reaches the result register, and throughput is one item per
// cycle when the sink keeps ready high. The input register refills whenever
// the result register is free or being drained that same cycle, or when the
// input register itself is empty, so the block takes a new item even while a
// finished result waits with an empty input stage. Out-of-range integer
// conversions saturate and NaN gives 0 for integer targets, both raising
// invalid; unknown type codes give size 0 with invalid set.
`default_nettype none
module double_to_typed_scalar_convert_core (
    input  var logic i_clk,
    input  var logic i_rst_n,
    dtsc_in_if.sink    i_in,
    dtsc_out_if.source o_out
);
    import dtsc_pkg::*;

    logic         r_in_vld;
    t_in_item     r_in;
    logic         r_out_vld;
    t_out_item    r_out;
    t_fp64_fields fields;
    logic [63:0]  int_bits;
    logic         int_inv;
    logic [31:0]  f32_bits;
    t_out_item    n_out;
    logic         adv;

    // stage 2 moves when its result slot is empty or being taken
    assign adv         = !r_out_vld || o_out.ready;
    assign i_in.ready  = adv || !r_in_vld;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // field split of the registered double
    always_comb begin
        fields.neg    = r_in.value_bits[63];
        fields.ex     = r_in.value_bits[62:52];
        fields.fr     = r_in.value_bits[51:0];
        fields.is_nan = (fields.ex == 11'h7FF) && (fields.fr != 52'd0);
        fields.is_inf = (fields.ex == 11'h7FF) && (fields.fr == 52'd0);
    end

    dtsc_int_conv u_int (.i_f(fields), .i_kind(r_in.kind),
        .o_bits(int_bits), .o_invalid(int_inv));
    dtsc_f32_conv u_f32 (.i_f(fields), .o_bits(f32_bits));

    // type select with size code
    always_comb begin
        n_out = '0;
        unique case (r_in.kind) inside
            K_BOOL: begin
                n_out.result_bits = {63'd0, r_in.value_bits[62:0] != 63'd0};
                n_out.size_bytes  = 4'd1;
            end
            K_S8, K_U8, K_S16, K_U16, K_S32, K_U32, K_S64, K_U64: begin
                n_out.result_bits = int_bits;
                n_out.invalid     = int_inv;
                n_out.size_bytes  = (r_in.kind <= K_U8) ? 4'd1 :
                                    (r_in.kind <= K_U16) ? 4'd2 :
                                    (r_in.kind <= K_U32) ? 4'd4 : 4'd8;
            end
            K_F32: begin
                n_out.result_bits = {32'd0, f32_bits};
                n_out.size_bytes  = 4'd4;
            end
            K_F64: begin
                n_out.result_bits = r_in.value_bits;
                n_out.size_bytes  = 4'd8;
            end
            default: begin
                n_out.invalid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_out))
        else $error("result changed while stalled");
    // bool and float targets never flag invalid
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && (r_in.kind == K_BOOL || r_in.kind == K_F32 ||
        r_in.kind == K_F64) |-> !n_out.invalid)
        else $error("invalid on non-integer target");
    // stage 1 data is never dropped
    a_nodrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("input stage lost an item");
endmodule
`default_nettype wire
